### src/vrp_pkg.sv
// Shared types, widths and constants for the vertex rotate and project pipeline.
`timescale 1ns / 1ps
`default_nettype none

package vrp_pkg;

   // Screen geometry
   localparam int SCREEN_WIDTH  = 100;
   localparam int SCREEN_HEIGHT = 42;
   localparam int HALF_W        = SCREEN_WIDTH / 2;
   localparam int HALF_H        = SCREEN_HEIGHT / 2;

   // Port field widths
   localparam int COORD_W    = 16;
   localparam int TRIG_W     = 16;
   localparam int FOCAL_W    = 15;
   localparam int SCR_W      = 12;
   localparam int DEPTH_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Q2.14 rounding back to Q.8
   localparam int TRIG_FRAC  = 14;
   localparam int ROUND_HALF = 1 << (TRIG_FRAC - 1);

   // Rotation datapath widths (products, sums, rounded results)
   localparam int PA_W = 32;
   localparam int SA_W = 33;
   localparam int R1_W = 19;
   localparam int PB_W = 35;
   localparam int SB_W = 36;
   localparam int R2_W = 20;
   localparam int PC_W = 36;
   localparam int SC_W = 37;
   localparam int R3_W = 21;

   // Projection datapath widths
   localparam int DEN_S_W  = 21;                 // focal + z, signed
   localparam int DEN_W    = 19;                 // positive divisor
   localparam int MAG_W    = 20;                 // |rotated coordinate|
   localparam int PROD_W   = MAG_W + FOCAL_W;    // |c| * focal
   localparam int NUM_FRAC = 7;                  // 2*c*f / 256 = c*f / 128
   localparam int NUM_W    = PROD_W - NUM_FRAC;  // dividend
   localparam int QUO_W    = 13;                 // quotient bits, one per stage
   localparam int REM_W    = DEN_W;
   localparam int CALC_W   = 15;                 // final offset arithmetic

   localparam int FRONT_STAGES = 8;

   // Saturation limits
   localparam logic signed [SCR_W-1:0]   SCR_MAX   = {1'b0, {(SCR_W-1){1'b1}}};
   localparam logic signed [SCR_W-1:0]   SCR_MIN   = {1'b1, {(SCR_W-1){1'b0}}};
   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

   // Screen center offsets
   localparam logic signed [CALC_W-1:0] HALF_X = CALC_W'(HALF_W);
   localparam logic signed [CALC_W-1:0] HALF_Y = CALC_W'(HALF_H);
   localparam logic signed [SCR_W-1:0]  HALF_X_SCR =
      (HALF_X > CALC_W'(SCR_MAX)) ? SCR_MAX : SCR_W'(HALF_X);
   localparam logic signed [SCR_W-1:0]  HALF_Y_SCR =
      (HALF_Y > CALC_W'(SCR_MAX)) ? SCR_MAX : SCR_W'(HALF_Y);

   // Register reset values
   localparam logic signed [TRIG_W-1:0] TRIG_ZERO   = '0;
   localparam logic signed [TRIG_W-1:0] TRIG_ONE    = TRIG_W'(1 << TRIG_FRAC);
   localparam logic [FOCAL_W-1:0]       FOCAL_RESET = FOCAL_W'(2560);

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIN_A,
      CSR_COS_A,
      CSR_SIN_B,
      CSR_COS_B,
      CSR_SIN_C,
      CSR_COS_C,
      CSR_FOCAL
   } csr_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic signed [COORD_W-1:0] vertex_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [SCR_W-1:0]   screen_x;
      logic signed [SCR_W-1:0]   screen_y;
      logic signed [DEPTH_W-1:0] depth;
      logic                      behind_viewer;
   } rsp_payload_type;

   // Divider operand: starting remainder and the dividend bits still to shift in
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] num;
   } div_op_type;

   typedef struct packed {
      logic [QUO_W-1:0] quo;
      logic             rem_nz;
   } div_res_type;

   // Per-lane flags traveling alongside the divider
   typedef struct packed {
      logic neg;
      logic zero;
      logic ovf;
      logic lownz;
   } lane_flags_type;

   typedef struct packed {
      lane_flags_type            fx;
      lane_flags_type            fy;
      logic                      behind;
      logic signed [DEPTH_W-1:0] depth;
   } pipe_side_type;

endpackage

`default_nettype wire

### src/vrp_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none

module vrp_div
   import vrp_pkg::*;
(
   input  logic             clock,
   input  logic             advance,
   input  logic [DEN_W-1:0] den,
   input  div_op_type       op,
   output div_res_type      res
);

   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [REM_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] num_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   logic [DEN_W-1:0] den_in [QUO_W];
   logic [REM_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] num_in [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   // stage sources: operand for the first step, previous stage after that
   logic [DEN_W-1:0] den_src [QUO_W];
   logic [REM_W-1:0] rem_src [QUO_W];
   logic [QUO_W-1:0] num_src [QUO_W];
   logic [QUO_W-1:0] quo_src [QUO_W];

   always_comb begin
      den_src[0] = den;
      rem_src[0] = op.rem;
      num_src[0] = op.num;
      quo_src[0] = '0;
      for (int k = 1; k < QUO_W; k++) begin
         den_src[k] = den_ff[k-1];
         rem_src[k] = rem_ff[k-1];
         num_src[k] = num_ff[k-1];
         quo_src[k] = quo_ff[k-1];
      end
   end

   // one shift, compare and subtract per stage
   always_comb begin
      logic [REM_W:0] trial;
      for (int k = 0; k < QUO_W; k++) begin
         trial     = {rem_src[k], num_src[k][QUO_W-1]};
         den_in[k] = den_src[k];
         num_in[k] = {num_src[k][QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, den_src[k]}) begin
            rem_in[k] = REM_W'(trial - {1'b0, den_src[k]});
            quo_in[k] = {quo_src[k][QUO_W-2:0], 1'b1};
         end else begin
            rem_in[k] = REM_W'(trial);
            quo_in[k] = {quo_src[k][QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < QUO_W; k++) begin
            den_ff[k] <= den_in[k];
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign res.quo    = quo_ff[QUO_W-1];
   assign res.rem_nz = |rem_ff[QUO_W-1];

endmodule

`default_nettype wire

### src/vertex_rotate_project.sv
// Top: XYZ Euler rotation and perspective projection, one vertex per cycle if unstalled.
//
//   channel  ports                           direction  payload
//   req      req_valid/req_ready/req_data    in         vertex_x, vertex_y, vertex_z
//   rsp      rsp_valid/rsp_ready/rsp_data    out        screen_x, screen_y, depth, behind
//   csr      csr_write_en/csr_index/wdata    in         sin/cos a,b,c and focal_distance
//
// Throughput is one vertex per cycle unless the output stalls; the pipeline has eight
// rotation and projection stages, thirteen divider stages (one quotient bit each), and
// an output register. The perspective divide pipeline sets the depth.
// Synchronous active-high reset clears valid bits and loads the register defaults.
// When the output register holds an untaken result, the whole pipeline holds.
`timescale 1ns / 1ps
`default_nettype none

module vertex_rotate_project
   import vrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,

   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic signed [TRIG_W-1:0] sin_a_ff, cos_a_ff, sin_b_ff, cos_b_ff, sin_c_ff, cos_c_ff;
   logic [FOCAL_W-1:0]       focal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_a_ff <= TRIG_ZERO;
         cos_a_ff <= TRIG_ONE;
         sin_b_ff <= TRIG_ZERO;
         cos_b_ff <= TRIG_ONE;
         sin_c_ff <= TRIG_ZERO;
         cos_c_ff <= TRIG_ONE;
         focal_ff <= FOCAL_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SIN_A: sin_a_ff <= $signed(csr_wdata);
            CSR_COS_A: cos_a_ff <= $signed(csr_wdata);
            CSR_SIN_B: sin_b_ff <= $signed(csr_wdata);
            CSR_COS_B: cos_b_ff <= $signed(csr_wdata);
            CSR_SIN_C: sin_c_ff <= $signed(csr_wdata);
            CSR_COS_C: cos_c_ff <= $signed(csr_wdata);
            CSR_FOCAL: focal_ff <= csr_wdata[FOCAL_W-1:0];
            default: ;
         endcase
      end
   end

   // global pipeline enable: move when the output slot is free or being taken
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // valid bits
   logic [FRONT_STAGES-1:0] front_vld_ff;
   logic [QUO_W-1:0]        div_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= '0;
         div_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         front_vld_ff <= {front_vld_ff[FRONT_STAGES-2:0], req_valid};
         div_vld_ff   <= {div_vld_ff[QUO_W-2:0], front_vld_ff[FRONT_STAGES-1]};
         rsp_valid_ff <= div_vld_ff[QUO_W-1];
      end
   end

   // stage 1: X-axis rotation products
   logic signed [PA_W-1:0]    pa_ff [4];
   logic signed [COORD_W-1:0] vx1_ff;

   // stage 2: X-axis rotation sums, rounded
   logic signed [SA_W-1:0]    sum_a0, sum_a1;
   logic signed [R1_W-1:0]    y1_in, z1_in;
   logic signed [R1_W-1:0]    y1_2_ff, z1_2_ff;
   logic signed [COORD_W-1:0] vx2_ff;

   always_comb begin
      sum_a0 = SA_W'(pa_ff[0]) - SA_W'(pa_ff[1]) + SA_W'(ROUND_HALF);
      sum_a1 = SA_W'(pa_ff[2]) + SA_W'(pa_ff[3]) + SA_W'(ROUND_HALF);
      y1_in  = R1_W'(sum_a0 >>> TRIG_FRAC);
      z1_in  = R1_W'(sum_a1 >>> TRIG_FRAC);
   end

   // stage 3: Y-axis rotation products
   logic signed [PB_W-1:0] pb_ff [4];
   logic signed [R1_W-1:0] y1_3_ff;

   // stage 4: Y-axis rotation sums, rounded
   logic signed [SB_W-1:0] sum_b0, sum_b1;
   logic signed [R2_W-1:0] z2_in, x2_in;
   logic signed [R2_W-1:0] x2_4_ff, z2_4_ff;
   logic signed [R1_W-1:0] y1_4_ff;

   always_comb begin
      sum_b0 = SB_W'(pb_ff[0]) - SB_W'(pb_ff[1]) + SB_W'(ROUND_HALF);
      sum_b1 = SB_W'(pb_ff[2]) + SB_W'(pb_ff[3]) + SB_W'(ROUND_HALF);
      z2_in  = R2_W'(sum_b0 >>> TRIG_FRAC);
      x2_in  = R2_W'(sum_b1 >>> TRIG_FRAC);
   end

   // stage 5: Z-axis rotation products, perspective denominator
   logic signed [PC_W-1:0]    pc_ff [4];
   logic signed [R2_W-1:0]    z2_5_ff;
   logic signed [DEN_S_W-1:0] den_in;
   logic signed [DEN_S_W-1:0] den_5_ff;

   assign den_in = $signed(DEN_S_W'(focal_ff)) + DEN_S_W'(z2_4_ff);

   // stage 6: Z-axis rotation sums, rounded
   logic signed [SC_W-1:0]    sum_c0, sum_c1;
   logic signed [R3_W-1:0]    x3_in, y3_in;
   logic signed [R3_W-1:0]    x3_6_ff, y3_6_ff;
   logic signed [R2_W-1:0]    z2_6_ff;
   logic signed [DEN_S_W-1:0] den_6_ff;

   always_comb begin
      sum_c0 = SC_W'(pc_ff[0]) - SC_W'(pc_ff[1]) + SC_W'(ROUND_HALF);
      sum_c1 = SC_W'(pc_ff[2]) + SC_W'(pc_ff[3]) + SC_W'(ROUND_HALF);
      x3_in  = R3_W'(sum_c0 >>> TRIG_FRAC);
      y3_in  = R3_W'(sum_c1 >>> TRIG_FRAC);
   end

   // stage 7: magnitude times focal, sign flags, depth saturation
   logic [MAG_W-1:0]          mag_x, mag_y;
   logic                      behind_in;
   logic signed [DEPTH_W-1:0] depth_in;
   logic [PROD_W-1:0]         px_7_ff, py_7_ff;
   lane_flags_type            fx_7_ff, fy_7_ff;
   logic                      behind_7_ff;
   logic [DEN_W-1:0]          den_7_ff;
   logic signed [DEPTH_W-1:0] depth_7_ff;

   always_comb begin
      mag_x     = x3_6_ff[R3_W-1] ? MAG_W'(-x3_6_ff) : MAG_W'(x3_6_ff);
      mag_y     = y3_6_ff[R3_W-1] ? MAG_W'(-y3_6_ff) : MAG_W'(y3_6_ff);
      behind_in = den_6_ff[DEN_S_W-1] || (den_6_ff == '0);
      priority if (z2_6_ff > R2_W'(DEPTH_MAX)) begin
         depth_in = DEPTH_MAX;
      end else if (z2_6_ff < R2_W'(DEPTH_MIN)) begin
         depth_in = DEPTH_MIN;
      end else begin
         depth_in = DEPTH_W'(z2_6_ff);
      end
   end

   // stage 8: overflow check and divider operands
   logic [NUM_W-1:0] ax, ay;
   div_op_type       opx_in, opy_in;
   lane_flags_type   fx_in, fy_in;
   div_op_type       opx_8_ff, opy_8_ff;
   logic [DEN_W-1:0] den_8_ff;
   pipe_side_type    side_8_ff;

   always_comb begin
      ax         = px_7_ff[PROD_W-1:NUM_FRAC];
      ay         = py_7_ff[PROD_W-1:NUM_FRAC];
      opx_in.rem = REM_W'(ax[NUM_W-1:QUO_W]);
      opx_in.num = ax[QUO_W-1:0];
      opy_in.rem = REM_W'(ay[NUM_W-1:QUO_W]);
      opy_in.num = ay[QUO_W-1:0];
      fx_in       = fx_7_ff;
      fy_in       = fy_7_ff;
      // quotient would need more than QUO_W bits
      fx_in.ovf   = DEN_W'(ax[NUM_W-1:QUO_W]) >= den_7_ff;
      fy_in.ovf   = DEN_W'(ay[NUM_W-1:QUO_W]) >= den_7_ff;
      fx_in.lownz = |px_7_ff[NUM_FRAC-1:0];
      fy_in.lownz = |py_7_ff[NUM_FRAC-1:0];
   end

   // datapath registers, all held on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff[0] <= cos_a_ff * $signed(req_data.vertex_y);
         pa_ff[1] <= sin_a_ff * $signed(req_data.vertex_z);
         pa_ff[2] <= sin_a_ff * $signed(req_data.vertex_y);
         pa_ff[3] <= cos_a_ff * $signed(req_data.vertex_z);
         vx1_ff   <= req_data.vertex_x;

         y1_2_ff  <= y1_in;
         z1_2_ff  <= z1_in;
         vx2_ff   <= vx1_ff;

         pb_ff[0] <= cos_b_ff * z1_2_ff;
         pb_ff[1] <= sin_b_ff * vx2_ff;
         pb_ff[2] <= sin_b_ff * z1_2_ff;
         pb_ff[3] <= cos_b_ff * vx2_ff;
         y1_3_ff  <= y1_2_ff;

         x2_4_ff  <= x2_in;
         z2_4_ff  <= z2_in;
         y1_4_ff  <= y1_3_ff;

         pc_ff[0] <= cos_c_ff * x2_4_ff;
         pc_ff[1] <= sin_c_ff * y1_4_ff;
         pc_ff[2] <= sin_c_ff * x2_4_ff;
         pc_ff[3] <= cos_c_ff * y1_4_ff;
         z2_5_ff  <= z2_4_ff;
         den_5_ff <= den_in;

         x3_6_ff  <= x3_in;
         y3_6_ff  <= y3_in;
         z2_6_ff  <= z2_5_ff;
         den_6_ff <= den_5_ff;

         px_7_ff       <= mag_x * focal_ff;
         py_7_ff       <= mag_y * focal_ff;
         fx_7_ff.neg   <= x3_6_ff[R3_W-1];
         fx_7_ff.zero  <= (x3_6_ff == '0);
         fx_7_ff.ovf   <= 1'b0;
         fx_7_ff.lownz <= 1'b0;
         fy_7_ff.neg   <= y3_6_ff[R3_W-1];
         fy_7_ff.zero  <= (y3_6_ff == '0);
         fy_7_ff.ovf   <= 1'b0;
         fy_7_ff.lownz <= 1'b0;
         behind_7_ff   <= behind_in;
         den_7_ff      <= den_6_ff[DEN_W-1:0];
         depth_7_ff    <= depth_in;

         opx_8_ff         <= opx_in;
         opy_8_ff         <= opy_in;
         den_8_ff         <= den_7_ff;
         side_8_ff.fx     <= fx_in;
         side_8_ff.fy     <= fy_in;
         side_8_ff.behind <= behind_7_ff;
         side_8_ff.depth  <= depth_7_ff;
      end
   end

   // perspective divide, one lane per coordinate
   div_res_type res_x, res_y;

   vrp_div u_div_x (
      .clock   (clock),
      .advance (advance),
      .den     (den_8_ff),
      .op      (opx_8_ff),
      .res     (res_x)
   );

   vrp_div u_div_y (
      .clock   (clock),
      .advance (advance),
      .den     (den_8_ff),
      .op      (opy_8_ff),
      .res     (res_y)
   );

   // sideband keeps step with the divider stages
   pipe_side_type side_ff [QUO_W];

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_8_ff;
         for (int k = 1; k < QUO_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // truncate toward zero around the screen center, then saturate
   function automatic logic signed [SCR_W-1:0] place_coord(
      input lane_flags_type              f,
      input logic                        behind,
      input div_res_type                 r,
      input logic signed [CALC_W-1:0]    half
   );
      logic signed [CALC_W-1:0] q;
      logic signed [CALC_W-1:0] val;
      logic signed [SCR_W-1:0]  out;
      q = $signed(CALC_W'(r.quo));
      priority if (f.zero) begin
         val = half;
      end else if (behind || f.ovf) begin
         val = f.neg ? CALC_W'(SCR_MIN) : CALC_W'(SCR_MAX);
      end else if (!f.neg) begin
         val = half + q;
      end else if (q < half) begin
         // result stays non-negative: round the offset up
         val = half - q - CALC_W'(f.lownz || r.rem_nz);
      end else begin
         val = half - q;
      end
      priority if (val > CALC_W'(SCR_MAX)) begin
         out = SCR_MAX;
      end else if (val < CALC_W'(SCR_MIN)) begin
         out = SCR_MIN;
      end else begin
         out = SCR_W'(val);
      end
      return out;
   endfunction

   // output register
   rsp_payload_type rsp_data_in, rsp_data_ff;

   always_comb begin
      rsp_data_in.screen_x      = place_coord(side_ff[QUO_W-1].fx, side_ff[QUO_W-1].behind,
                                              res_x, HALF_X);
      rsp_data_in.screen_y      = place_coord(side_ff[QUO_W-1].fy, side_ff[QUO_W-1].behind,
                                              res_y, HALF_Y);
      rsp_data_in.depth         = side_ff[QUO_W-1].depth;
      rsp_data_in.behind_viewer = side_ff[QUO_W-1].behind;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a point behind the viewer lands on an edge or on the screen center
   a_behind_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.behind_viewer |->
         (rsp_data.screen_x == SCR_MAX || rsp_data.screen_x == SCR_MIN ||
          rsp_data.screen_x == HALF_X_SCR) &&
         (rsp_data.screen_y == SCR_MAX || rsp_data.screen_y == SCR_MIN ||
          rsp_data.screen_y == HALF_Y_SCR))
      else $error("behind-viewer result not saturated");

   // a stalled output freezes the divider occupancy and its sideband
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=>
         $stable(div_vld_ff) && $stable(front_vld_ff) && $stable(side_ff[QUO_W-1]))
      else $error("pipeline moved during output stall");
`endif

endmodule

`default_nettype wire

### test/tb_vertex_rotate_project.sv
// Self-checking testbench for the vertex rotate and perspective project pipeline.
`timescale 1ns / 1ps

module tb_vertex_rotate_project;
   import vrp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_SLACK = 30;    // pipeline latency plus margin
   localparam int HOLD_CYCLES = 150;   // long receiver stall, fills the pipe
   localparam int IDLE_PCT    = 35;
   localparam int SETTINGS_N  = 7;
   localparam int DIRECTED_N  = 15;

   // Spare register index, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(7);

   typedef struct packed {
      req_payload_type vertex;
      logic            typed;      // result below is known by inspection
      rsp_payload_type result;
   } vertex_case_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the register file
   logic signed [TRIG_W-1:0] sin_a_r = TRIG_ZERO;
   logic signed [TRIG_W-1:0] cos_a_r = TRIG_ONE;
   logic signed [TRIG_W-1:0] sin_b_r = TRIG_ZERO;
   logic signed [TRIG_W-1:0] cos_b_r = TRIG_ONE;
   logic signed [TRIG_W-1:0] sin_c_r = TRIG_ZERO;
   logic signed [TRIG_W-1:0] cos_c_r = TRIG_ONE;
   logic [FOCAL_W-1:0]       focal_r = FOCAL_RESET;

   rsp_payload_type expected_pixels [$];
   vertex_case_type vertex_cases [DIRECTED_N];

   logic steady  = 1'b0;   // both sides run without idling
   logic squeeze = 1'b0;   // request for the long receiver stall
   logic squeeze_done = 1'b0;
   int   hold_left = 0;
   int   cycle_count = 0;
   int   fail_count = 0;
   int   sent_count = 0;
   int   behind_seen = 0;

   vertex_rotate_project dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Q2.14 product sum back to Q.8, ties toward +inf
   function automatic longint q14_round(input longint v);
      return (v + longint'(ROUND_HALF)) >>> TRIG_FRAC;
   endfunction

   // Perspective divide of one rotated coordinate, center offset, saturation
   function automatic logic signed [SCR_W-1:0] screen_coord(input longint c, input longint den,
                                                            input longint half);
      longint q;
      if (den <= 0) begin
         if (c > 0)
            q = longint'(SCR_MAX);
         else if (c < 0)
            q = longint'(SCR_MIN);
         else
            q = half;
      end else begin
         q = (2 * c * longint'(focal_r) + half * 256 * den) / (256 * den);
      end
      if (q > longint'(SCR_MAX))
         q = longint'(SCR_MAX);
      else if (q < longint'(SCR_MIN))
         q = longint'(SCR_MIN);
      return SCR_W'(q);
   endfunction

   // Rotate about X, Y, Z, then project
   function automatic rsp_payload_type project_vertex(input req_payload_type v);
      longint vx, vy, vz, y1, z1, x2, z2, x3, y3, den, d;
      rsp_payload_type r;
      vx = longint'(v.vertex_x);
      vy = longint'(v.vertex_y);
      vz = longint'(v.vertex_z);
      y1 = q14_round(longint'(cos_a_r) * vy - longint'(sin_a_r) * vz);
      z1 = q14_round(longint'(sin_a_r) * vy + longint'(cos_a_r) * vz);
      x2 = q14_round(longint'(cos_b_r) * vx + longint'(sin_b_r) * z1);
      z2 = q14_round(longint'(cos_b_r) * z1 - longint'(sin_b_r) * vx);
      x3 = q14_round(longint'(cos_c_r) * x2 - longint'(sin_c_r) * y1);
      y3 = q14_round(longint'(sin_c_r) * x2 + longint'(cos_c_r) * y1);
      den = longint'(focal_r) + z2;
      r.screen_x = screen_coord(x3, den, HALF_W);
      r.screen_y = screen_coord(y3, den, HALF_H);
      d = z2;
      if (d > longint'(DEPTH_MAX))
         d = longint'(DEPTH_MAX);
      else if (d < longint'(DEPTH_MIN))
         d = longint'(DEPTH_MIN);
      r.depth = DEPTH_W'(d);
      r.behind_viewer = (den <= 0);
      return r;
   endfunction

   function automatic vertex_case_type vtx_row(input int vx, input int vy, input int vz,
                                               input logic typed, input int sx, input int sy,
                                               input int d, input logic b);
      vertex_case_type r;
      r.vertex.vertex_x = COORD_W'(vx);
      r.vertex.vertex_y = COORD_W'(vy);
      r.vertex.vertex_z = COORD_W'(vz);
      r.typed = typed;
      r.result.screen_x = SCR_W'(sx);
      r.result.screen_y = SCR_W'(sy);
      r.result.depth = DEPTH_W'(d);
      r.result.behind_viewer = b;
      return r;
   endfunction

   // Mostly on-screen magnitudes, some wide, a few exact zeros
   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(7))
         0: return '0;
         1, 2, 3: return COORD_W'(int'($urandom_range(4096)) - 2048);
         4, 5: return COORD_W'(int'($urandom_range(16384)) - 8192);
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // One input transfer; the expectation is queued when it is accepted
   task automatic send_vertex(input req_payload_type v, input logic typed,
                              input rsp_payload_type fixed_result);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= v;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expected_pixels.push_back(typed ? fixed_result : project_vertex(v));
      sent_count++;
   endtask

   task automatic send_random(input int n);
      req_payload_type v;
      repeat (n) begin
         v.vertex_x = rand_coord();
         v.vertex_y = rand_coord();
         v.vertex_z = rand_coord();
         send_vertex(v, 1'b0, '0);
      end
   endtask

   // Stop offering, let the pipe empty, then allow its latency to pass
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Leaves the write enable high; the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      case (idx)
         CSR_SIN_A: sin_a_r = val;
         CSR_COS_A: cos_a_r = val;
         CSR_SIN_B: sin_b_r = val;
         CSR_COS_B: cos_b_r = val;
         CSR_SIN_C: sin_c_r = val;
         CSR_COS_C: cos_c_r = val;
         CSR_FOCAL: focal_r = val[FOCAL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_rotation(input int sa, input int ca, input int sb, input int cb,
                                input int sc, input int cc, input int f);
      write_reg(CSR_SIN_A, CSR_DATA_W'(sa));
      write_reg(CSR_COS_A, CSR_DATA_W'(ca));
      write_reg(CSR_SIN_B, CSR_DATA_W'(sb));
      write_reg(CSR_COS_B, CSR_DATA_W'(cb));
      write_reg(CSR_SIN_C, CSR_DATA_W'(sc));
      write_reg(CSR_COS_C, CSR_DATA_W'(cc));
      write_reg(CSR_FOCAL, CSR_DATA_W'(f));
   endtask

   // Result side: random stalls, one long hold-off, and the scoreboard
   always @(posedge clock) begin : rsp_side
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result transfer: %p", rsp_data);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.behind_viewer)
                  behind_seen++;
               if (rsp_data.screen_x !== want.screen_x) begin
                  $error("screen_x: expected %0d, got %0d", want.screen_x, rsp_data.screen_x);
                  fail_count++;
               end
               if (rsp_data.screen_y !== want.screen_y) begin
                  $error("screen_y: expected %0d, got %0d", want.screen_y, rsp_data.screen_y);
                  fail_count++;
               end
               if (rsp_data.depth !== want.depth) begin
                  $error("depth: expected %0d, got %0d", want.depth, rsp_data.depth);
                  fail_count++;
               end
               if (rsp_data.behind_viewer !== want.behind_viewer) begin
                  $error("behind_viewer: expected %0d, got %0d", want.behind_viewer,
                         rsp_data.behind_viewer);
                  fail_count++;
               end
            end
         end
         if (squeeze && !squeeze_done) begin
            hold_left = HOLD_CYCLES;
            squeeze_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      int n_items;
      // Identity rotation, focal 10.0: x3 = vx, y3 = vy, depth = vz, den = 2560 + vz
      vertex_cases = '{
         vtx_row(0, 0, 0,                 1'b1,    50,    21,      0, 1'b0),
         vtx_row(256, 0, 0,               1'b1,    52,    21,      0, 1'b0),
         vtx_row(0, -256, 0,              1'b1,    50,    19,      0, 1'b0),
         vtx_row(32767, 32767, 32767,     1'b0,     0,     0,      0, 1'b0),
         vtx_row(-32768, -32768, -32768,  1'b1, -2048, -2048, -32768, 1'b1),
         vtx_row(32767, 32767, -32768,    1'b1,  2047,  2047, -32768, 1'b1),
         // focal plus depth exactly zero, zero coordinates land on the center
         vtx_row(0, 0, -2560,             1'b1,    50,    21,  -2560, 1'b1),
         vtx_row(0, 0, -2559,             1'b1,    50,    21,  -2559, 1'b0),
         // smallest positive divisor, coordinates saturate
         vtx_row(32767, -32768, -2559,    1'b1,  2047, -2048,  -2559, 1'b0),
         vtx_row(-1, 1, 0,                1'b0,     0,     0,      0, 1'b0),
         vtx_row('h5555, 'hAAAA, 'h00FF,  1'b0,     0,     0,      0, 1'b0),
         vtx_row('hAAAA, 'h5555, 'h7F00,  1'b0,     0,     0,      0, 1'b0),
         vtx_row(1, -1, -2561,            1'b1,  2047, -2048,  -2561, 1'b1),
         vtx_row(-32768, 0, 100,          1'b0,     0,     0,      0, 1'b0),
         vtx_row(0, 32767, -32768,        1'b1,    50,  2047, -32768, 1'b1)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vertex_cases[i])
         send_vertex(vertex_cases[i].vertex, vertex_cases[i].typed, vertex_cases[i].result);

      for (int ph = 0; ph < SETTINGS_N; ph++) begin
         wait_drained();
         n_items = 50;
         case (ph)
            // reset settings, no idling on either side
            0: n_items = 80;
            // moderate angles, with the long receiver hold-off
            1: begin
               load_rotation(8192, 14189, -8192, 14189, 11585, 11585, 2560);
               n_items = 60;
            end
            // trig extremes beyond unit range, focal with the unused top bit set
            2: load_rotation(-32768, 32767, 32767, -32768, -16384, 16384, 'hFFFF);
            // quarter turns, focal zero, and a write to the spare index
            3: begin
               load_rotation(16384, 0, -16384, 0, 0, -16384, 'h8000);
               write_reg(CSR_SPARE, 16'h1234);
            end
            // random unit-range angles, smallest nonzero focal
            4: load_rotation(int'($urandom_range(32768)) - 16384,
                             int'($urandom_range(32768)) - 16384,
                             int'($urandom_range(32768)) - 16384,
                             int'($urandom_range(32768)) - 16384,
                             int'($urandom_range(32768)) - 16384,
                             int'($urandom_range(32768)) - 16384, 1);
            // arbitrary register contents
            5: begin
               load_rotation($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(32767, 1));
               write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
            end
            // back to identity, largest focal
            default: load_rotation(0, 16384, 0, 16384, 0, 16384, 32767);
         endcase
         csr_write_en <= 1'b0;
         steady <= (ph == 0);
         if (ph == 1)
            squeeze <= 1'b1;
         send_random(n_items);
      end

      wait_drained();
      $display("Sent %0d vertices across %0d register settings plus reset defaults;",
               sent_count, SETTINGS_N - 1);
      $display("%0d results were behind the viewer, one %0d-cycle output stall.",
               behind_seen, HOLD_CYCLES);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### vertex_rotate_project.f
src/vrp_pkg.sv
src/vrp_div.sv
src/vertex_rotate_project.sv
test/tb_vertex_rotate_project.sv
